// ===== rtl/mi3_pkg.sv =====
// Shared widths, types and cofactor selection for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_WIDTH = 32;

  // Derived widths
  localparam int W    = ENTRY_WIDTH;
  localparam int CW   = 2 * W + 1;                 // signed cofactor
  localparam int CMW  = 2 * W;                     // cofactor magnitude
  localparam int PW   = 2 * W + 1;                 // determinant partial product
  localparam int DW   = 3 * W + 3;                 // signed determinant
  localparam int DMW  = 3 * W + 2;                 // determinant magnitude
  localparam int QB   = W + 2;                     // quotient bits, one extra for rounding
  localparam int SH   = 2 * FRAC_BITS + 1;         // numerator scale
  localparam int NW   = CMW + SH;                  // scaled numerator
  localparam int R0W  = NW - QB;                   // numerator bits above quotient range
  localparam int RW   = (DW > R0W + 1) ? DW : R0W + 1;  // divider remainder
  localparam int NS   = QB + 9;                    // register stages, input to output

  typedef logic [8:0][W-1:0] mat_t;

  // Cofactor k = e[p]*e[q] - e[s]*e[t]; n selects p, q, s, t
  function automatic logic [3:0] cof_idx(input int k, input int n);
    logic [15:0] row;
    case (k)
      0: row = 16'h4857;
      1: row = 16'h2718;
      2: row = 16'h1524;
      3: row = 16'h5638;
      4: row = 16'h0826;
      5: row = 16'h2305;
      6: row = 16'h3746;
      7: row = 16'h1607;
      8: row = 16'h0413;
      default: row = 16'h0000;
    endcase
    return row[(3 - n) * 4 +: 4];
  endfunction

endpackage

// ===== rtl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse: adjugate over determinant, Q16.16, fully pipelined.
// NS = 43 register stages at Q16.16, the first loaded at the input accept edge;
// out_tvalid is the valid bit of the last stage.
// Throughput: one matrix per cycle while out_tready is high; the restoring divider is
// unrolled, one stage per quotient bit and nine lanes wide, so items share no unit.
// Each stage holds its item while the next stage is full and stalled; bubbles collapse.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [9*W-1:0]      in_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22 from bit 0
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [9*W-1:0]      out_tdata,  // r00,r01,r02,r10,r11,r12,r20,r21,r22 from bit 0
  output logic [1:0]          out_tuser   // singular, saturated from bit 0
);

  localparam logic [QB-1:0] LIM_NEG = QB'(1) << (W - 1);
  localparam logic [QB-1:0] LIM_POS = LIM_NEG - QB'(1);

  // Valid bits and per-stage load enables
  logic [NS:1]  v_r;
  logic [NS+1:1] ld;

  // Payload, by stage
  mat_t                      me_r     [1:NS-1];
  logic signed [2*W-1:0]     pp_r     [9];
  logic signed [2*W-1:0]     ps_r     [9];
  logic signed [CW-1:0]      cf3_r    [9];
  logic signed [CW-1:0]      cf4_r    [9];
  logic signed [CW-1:0]      cf5_r    [9];
  logic signed [CW-1:0]      cf6_r    [9];
  logic signed [PW-1:0]      dlo_r    [3];
  logic signed [PW-1:0]      dhi_r    [3];
  logic signed [DW-1:0]      dt_r     [3];
  logic signed [DW-1:0]      det_r;
  logic [DMW-1:0]            dabs_r   [7:NS-1];
  logic                      zero_r   [7:NS-1];
  logic [8:0]                neg_r    [7:NS-1];
  logic [8:0][R0W-1:0]       r0_r;
  logic [8:0][QB-1:0]        nlo7_r;
  logic [8:0]                sat0_r   [8:NS-1];
  logic [8:0][QB-1:0]        nlo_r    [0:QB];
  logic [8:0][RW-1:0]        rem_r    [0:QB];
  logic [8:0][QB-1:0]        quo_r    [0:QB];
  mat_t                      res_r;
  logic                      sing_r;
  logic                      sat_r;

  // Next values
  logic signed [2*W-1:0]     pp_nxt   [9];
  logic signed [2*W-1:0]     ps_nxt   [9];
  logic signed [CW-1:0]      cf_nxt   [9];
  logic signed [PW-1:0]      dlo_nxt  [3];
  logic signed [PW-1:0]      dhi_nxt  [3];
  logic signed [DW-1:0]      dt_nxt   [3];
  logic signed [DW-1:0]      det_nxt;
  logic signed [DW-1:0]      dneg_val;
  logic [DMW-1:0]            dabs_nxt;
  logic [8:0]                neg_nxt;
  logic [8:0][QB-1:0]        nlo7_nxt;
  logic [8:0][R0W-1:0]       r0_nxt;
  logic [8:0]                sat0_nxt;
  logic [8:0][RW-1:0]        rem8_nxt;
  logic [8:0][QB-1:0]        nlo_nxt  [1:QB];
  logic [8:0][RW-1:0]        rem_nxt  [1:QB];
  logic [8:0][QB-1:0]        quo_nxt  [1:QB];
  mat_t                      res_nxt;
  logic                      sat_nxt;

  // Load a stage when it is empty or its item moves on
  always_comb begin
    ld[NS+1] = out_tready;
    for (int k = NS; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_tready  = ld[1];
  assign out_tvalid = v_r[NS];
  assign out_tdata  = res_r;
  assign out_tuser  = {sat_r, sing_r};

  // Stage 2: cofactor products
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pp_nxt[k] = $signed(me_r[1][cof_idx(k, 0)]) * $signed(me_r[1][cof_idx(k, 1)]);
      ps_nxt[k] = $signed(me_r[1][cof_idx(k, 2)]) * $signed(me_r[1][cof_idx(k, 3)]);
    end
  end

  // Stage 3: cofactors; stage 4: determinant partial products on first row
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cf_nxt[k] = CW'(pp_r[k]) - CW'(ps_r[k]);
    end
    for (int j = 0; j < 3; j++) begin
      dlo_nxt[j] = $signed(me_r[3][j]) * $signed({1'b0, cf3_r[3*j][W-1:0]});
      dhi_nxt[j] = $signed(me_r[3][j]) * $signed(cf3_r[3*j][CW-1:W]);
    end
  end

  // Stage 5: combine halves; stage 6: sum the three terms
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dt_nxt[j] = (DW'(dhi_r[j]) <<< W) + DW'(dlo_r[j]);
    end
    det_nxt = dt_r[0] + dt_r[1] + dt_r[2];
  end

  // Stage 7: magnitudes and result signs, split scaled numerator
  always_comb begin
    logic [CW-1:0] cneg_val;
    logic [NW-1:0] nnum;
    dneg_val = -det_r;
    dabs_nxt = det_r[DW-1] ? DMW'(dneg_val) : DMW'(det_r);
    for (int k = 0; k < 9; k++) begin
      cneg_val    = -cf6_r[k];
      neg_nxt[k]  = cf6_r[k][CW-1] ^ det_r[DW-1];
      nnum        = {(cf6_r[k][CW-1] ? CMW'(cneg_val) : CMW'(cf6_r[k])), SH'(0)};
      r0_nxt[k]   = nnum[NW-1:QB];
      nlo7_nxt[k] = nnum[QB-1:0];
    end
  end

  // Stage 8: quotient out of range check, load divider
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sat0_nxt[k] = RW'(r0_r[k]) >= RW'(dabs_r[7]);
      rem8_nxt[k] = RW'(r0_r[k]);
    end
  end

  // Divider: one quotient bit per stage in each lane
  always_comb begin
    logic [RW-1:0] t;
    logic          ge;
    for (int d = 1; d <= QB; d++) begin
      for (int k = 0; k < 9; k++) begin
        t  = {rem_r[d-1][k][RW-2:0], nlo_r[d-1][k][QB-1]};
        ge = t >= RW'(dabs_r[7+d]);
        rem_nxt[d][k] = ge ? (t - RW'(dabs_r[7+d])) : t;
        nlo_nxt[d][k] = nlo_r[d-1][k] << 1;
        quo_nxt[d][k] = {quo_r[d-1][k][QB-2:0], ge};
      end
    end
  end

  // Final stage: round half away from zero, saturate, apply sign
  always_comb begin
    logic [QB:0]   rnd1;
    logic [QB-1:0] rnd;
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic [QB-1:0] sval;
    logic          big;
    sat_nxt = 1'b0;
    for (int k = 0; k < 9; k++) begin
      rnd1 = (QB+1)'(quo_r[QB][k]) + (QB+1)'(1);
      rnd  = rnd1[QB:1];
      lim  = neg_r[NS-1][k] ? LIM_NEG : LIM_POS;
      big  = sat0_r[NS-1][k] || (rnd > lim);
      mag  = big ? lim : rnd;
      sval = neg_r[NS-1][k] ? (-mag) : mag;
      res_nxt[k] = sval[W-1:0];
      sat_nxt = sat_nxt | big;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (ld[1]) me_r[1] <= in_tdata;
    for (int k = 2; k <= NS-1; k++) begin
      if (ld[k]) me_r[k] <= me_r[k-1];
    end
    if (ld[2]) begin
      pp_r <= pp_nxt;
      ps_r <= ps_nxt;
    end
    if (ld[3]) cf3_r <= cf_nxt;
    if (ld[4]) begin
      cf4_r <= cf3_r;
      dlo_r <= dlo_nxt;
      dhi_r <= dhi_nxt;
    end
    if (ld[5]) begin
      cf5_r <= cf4_r;
      dt_r  <= dt_nxt;
    end
    if (ld[6]) begin
      cf6_r <= cf5_r;
      det_r <= det_nxt;
    end
    if (ld[7]) begin
      dabs_r[7]  <= dabs_nxt;
      zero_r[7]  <= (det_r == '0);
      neg_r[7]   <= neg_nxt;
      r0_r       <= r0_nxt;
      nlo7_r     <= nlo7_nxt;
    end
    for (int k = 8; k <= NS-1; k++) begin
      if (ld[k]) begin
        dabs_r[k] <= dabs_r[k-1];
        zero_r[k] <= zero_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end
    end
    if (ld[8]) begin
      sat0_r[8] <= sat0_nxt;
      rem_r[0]  <= rem8_nxt;
      nlo_r[0]  <= nlo7_r;
      quo_r[0]  <= '0;
    end
    for (int k = 9; k <= NS-1; k++) begin
      if (ld[k]) sat0_r[k] <= sat0_r[k-1];
    end
    for (int d = 1; d <= QB; d++) begin
      if (ld[8+d]) begin
        rem_r[d] <= rem_nxt[d];
        nlo_r[d] <= nlo_nxt[d];
        quo_r[d] <= quo_nxt[d];
      end
    end
    // Output: pass input through when the determinant is zero
    if (ld[NS]) begin
      res_r  <= zero_r[NS-1] ? me_r[NS-1] : res_nxt;
      sing_r <= zero_r[NS-1];
      sat_r  <= zero_r[NS-1] ? 1'b0 : sat_nxt;
    end
  end

endmodule
